FILE: rtl/core/bb3_pkg.sv
// ---------------------------------------------------------------------------
// bb3_pkg
// Shared types and constants of the edge-aware 3x3 box blur.
// ---------------------------------------------------------------------------
`default_nettype none

package bb3_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int SIZE_W      = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int CHAN_W      = 8;
  localparam int PIX_W       = 3 * CHAN_W;
  // four row slots: row y lives in slot y mod 4
  localparam int SLOT_W      = 2;
  localparam int ADDR_W      = SLOT_W + COL_W;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = 12;
  localparam int CNT_W       = 4;
  localparam int NUM_W       = 13;
  localparam int DIV_W       = 5;
  localparam int STEP_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } in_pix_t;

  typedef struct packed {
    logic [ROW_W-1:0]  out_row;
    logic [COL_W-1:0]  out_col;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              last_of_run;
  } out_pix_t;

  typedef struct packed {
    logic [ROW_W-1:0] h_last;
    logic [COL_W-1:0] w_last;
  } size_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             has_up;
    logic             last_row;
    logic             has_left;
    logic             last_col;
  } q_entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/bb3_ram.sv
// ---------------------------------------------------------------------------
// bb3_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/bb3_front.sv
// ---------------------------------------------------------------------------
// bb3_front
// Accepts pixels, writes the line store, tracks the raster position and
// queues a request for every pixel that completes one or more outputs.
// ---------------------------------------------------------------------------
`default_nettype none

module bb3_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire bb3_pkg::in_pix_t                 in_data,
  input  wire logic                             cfg_we,
  input  wire logic [bb3_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [bb3_pkg::SIZE_W-1:0]       cfg_wdata,
  input  wire logic                             q_empty,
  input  wire logic                             back_busy,
  output logic                                  push,
  output bb3_pkg::q_entry_t                     push_entry,
  output logic                                  st_we,
  output logic      [bb3_pkg::ADDR_W-1:0]       st_addr,
  output logic      [bb3_pkg::PIX_W-1:0]        st_wdata,
  output bb3_pkg::size_t                        size
);

  logic [bb3_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [bb3_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [bb3_pkg::ROW_W-1:0]  h_last_r, h_last_nxt;
  logic [bb3_pkg::COL_W-1:0]  w_last_r, w_last_nxt;
  logic [bb3_pkg::SIZE_W-1:0] wm1;
  logic [bb3_pkg::COL_W-1:0]  w_lim;
  logic [bb3_pkg::ROW_W-1:0]  h_lim;
  logic                       accept;

  // hold row 0 until the back end is done with the previous frame's rows
  assign in_ready = q_empty && !((row_r == '0) && back_busy);
  assign accept   = in_valid && in_ready;

  assign push_entry.row      = row_r;
  assign push_entry.col      = col_r;
  assign push_entry.has_up   = (row_r != '0);
  assign push_entry.last_row = (row_r == h_last_r);
  assign push_entry.has_left = (col_r != '0);
  assign push_entry.last_col = (col_r == w_last_r);
  assign push = accept && (push_entry.has_up || push_entry.last_row)
                       && (push_entry.has_left || push_entry.last_col);

  assign st_we    = accept;
  assign st_addr  = {row_r[bb3_pkg::SLOT_W-1:0], col_r};
  assign st_wdata = in_data;

  assign size.h_last = h_last_r;
  assign size.w_last = w_last_r;

  assign wm1 = cfg_wdata - bb3_pkg::SIZE_W'(1);

  always_comb begin
    if (cfg_wdata == '0) begin
      w_lim = '0;
    end else if (cfg_wdata > bb3_pkg::SIZE_W'(bb3_pkg::MAX_WIDTH)) begin
      w_lim = bb3_pkg::COL_W'(bb3_pkg::MAX_WIDTH - 1);
    end else begin
      w_lim = wm1[bb3_pkg::COL_W-1:0];
    end
    if (cfg_wdata == '0) begin
      h_lim = '0;
    end else if (cfg_wdata > bb3_pkg::SIZE_W'(bb3_pkg::MAX_HEIGHT)) begin
      h_lim = bb3_pkg::ROW_W'(bb3_pkg::MAX_HEIGHT - 1);
    end else begin
      h_lim = wm1[bb3_pkg::ROW_W-1:0];
    end
  end

  always_comb begin
    row_nxt    = row_r;
    col_nxt    = col_r;
    h_last_nxt = h_last_r;
    w_last_nxt = w_last_r;
    if (cfg_we && (cfg_idx == bb3_pkg::REG_WIDTH || cfg_idx == bb3_pkg::REG_HEIGHT)) begin
      // any size write restarts the frame
      if (cfg_idx == bb3_pkg::REG_WIDTH) begin
        w_last_nxt = w_lim;
      end else begin
        h_last_nxt = h_lim;
      end
      row_nxt = '0;
      col_nxt = '0;
    end else if (accept) begin
      if (col_r == w_last_r) begin
        col_nxt = '0;
        row_nxt = (row_r == h_last_r) ? '0 : row_r + bb3_pkg::ROW_W'(1);
      end else begin
        col_nxt = col_r + bb3_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      col_r    <= '0;
      h_last_r <= bb3_pkg::ROW_W'(bb3_pkg::MAX_HEIGHT - 1);
      w_last_r <= bb3_pkg::COL_W'(bb3_pkg::MAX_WIDTH - 1);
    end else begin
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      h_last_r <= h_last_nxt;
      w_last_r <= w_last_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bb3_queue.sv
// ---------------------------------------------------------------------------
// bb3_queue
// Short request queue between the front end and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module bb3_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire bb3_pkg::q_entry_t push_entry,
  input  wire logic              pop,
  output logic                   empty,
  output bb3_pkg::q_entry_t      head
);

  bb3_pkg::q_entry_t             mem_r [bb3_pkg::QUEUE_DEPTH];
  logic [bb3_pkg::QPTR_W-1:0]    wptr_r, wptr_nxt;
  logic [bb3_pkg::QPTR_W-1:0]    rptr_r, rptr_nxt;
  logic [bb3_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign head  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == bb3_pkg::QPTR_W'(bb3_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wptr_r + bb3_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == bb3_pkg::QPTR_W'(bb3_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rptr_r + bb3_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + bb3_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - bb3_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bb3_back.sv
// ---------------------------------------------------------------------------
// bb3_back
// Expands a request into its outputs; per output it reads the 3x3
// neighborhood from the line store, sums it and divides by the count.
// ---------------------------------------------------------------------------
`default_nettype none

module bb3_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire bb3_pkg::size_t               size,
  input  wire logic                         q_empty,
  input  wire bb3_pkg::q_entry_t            q_head,
  output logic                              q_pop,
  output logic                              busy,
  output logic      [bb3_pkg::ADDR_W-1:0]   rd_addr,
  input  wire logic [bb3_pkg::PIX_W-1:0]    rd_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output bb3_pkg::out_pix_t                 out_data
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_READ = 6'b000010,
    ST_ACC  = 6'b000100,
    ST_PREP = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_OUT  = 6'b100000
  } bb3_state_t;

  bb3_state_t                    st_r, st_nxt;
  bb3_pkg::q_entry_t             ent_r, ent_nxt;
  logic                          ji_r, ji_nxt;
  logic                          jj_r, jj_nxt;
  logic [1:0]                    dr_r, dr_nxt;
  logic [1:0]                    dc_r, dc_nxt;
  logic                          acc_en_r;
  logic [bb3_pkg::SUM_W-1:0]     sum_r [3];
  logic [bb3_pkg::SUM_W-1:0]     sum_nxt [3];
  logic [bb3_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [bb3_pkg::NUM_W-1:0]     rem_r [3];
  logic [bb3_pkg::NUM_W-1:0]     rem_nxt [3];
  logic [bb3_pkg::CHAN_W-1:0]    quo_r [3];
  logic [bb3_pkg::CHAN_W-1:0]    quo_nxt [3];
  logic [bb3_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic                          out_valid_r, out_valid_nxt;
  bb3_pkg::out_pix_t             out_data_r, out_data_nxt;

  logic [bb3_pkg::ROW_W-1:0]     orow;
  logic [bb3_pkg::COL_W-1:0]     ocol;
  logic                          row_job_last;
  logic                          col_job_last;
  logic                          job_last;
  logic                          nb_ok;
  logic [bb3_pkg::SLOT_W-1:0]    nb_slot;
  logic [bb3_pkg::COL_W-1:0]     nb_col;
  logic [bb3_pkg::CHAN_W-1:0]    chan [3];
  logic [bb3_pkg::DIV_W-1:0]     divisor;
  logic [bb3_pkg::NUM_W-1:0]     dsh;
  bb3_pkg::in_pix_t              rd_pix;

  assign rd_pix  = rd_data;
  assign chan[0] = rd_pix.red_in;
  assign chan[1] = rd_pix.green_in;
  assign chan[2] = rd_pix.blue_in;

  // first job of a request is one row/column back when that exists
  assign orow = (ent_r.has_up && !ji_r) ? ent_r.row - bb3_pkg::ROW_W'(1) : ent_r.row;
  assign ocol = (ent_r.has_left && !jj_r) ? ent_r.col - bb3_pkg::COL_W'(1) : ent_r.col;
  assign row_job_last = (ji_r == (ent_r.has_up && ent_r.last_row));
  assign col_job_last = (jj_r == (ent_r.has_left && ent_r.last_col));
  assign job_last     = row_job_last && col_job_last;

  assign nb_ok = !(dr_r == 2'd0 && orow == '0) && !(dr_r == 2'd2 && orow == size.h_last)
              && !(dc_r == 2'd0 && ocol == '0) && !(dc_r == 2'd2 && ocol == size.w_last);
  assign nb_slot = orow[bb3_pkg::SLOT_W-1:0] + dr_r - 2'd1;
  assign nb_col  = ocol + bb3_pkg::COL_W'(dc_r) - bb3_pkg::COL_W'(1);
  assign rd_addr = {nb_slot, nb_col};

  assign divisor = {cnt_r, 1'b0};
  assign dsh     = bb3_pkg::NUM_W'(divisor) << step_r;

  assign q_pop     = (st_r == ST_IDLE) && !q_empty;
  assign busy      = (st_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    st_nxt        = st_r;
    ent_nxt       = ent_r;
    ji_nxt        = ji_r;
    jj_nxt        = jj_r;
    dr_nxt        = dr_r;
    dc_nxt        = dc_r;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    for (int ch = 0; ch < 3; ch++) begin
      sum_nxt[ch] = acc_en_r ? sum_r[ch] + bb3_pkg::SUM_W'(chan[ch]) : sum_r[ch];
      rem_nxt[ch] = rem_r[ch];
      quo_nxt[ch] = quo_r[ch];
    end

    case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          ent_nxt = q_head;
          ji_nxt  = 1'b0;
          jj_nxt  = 1'b0;
          dr_nxt  = 2'd0;
          dc_nxt  = 2'd0;
          cnt_nxt = '0;
          for (int ch = 0; ch < 3; ch++) begin
            sum_nxt[ch] = '0;
          end
          st_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (nb_ok) begin
          cnt_nxt = cnt_r + bb3_pkg::CNT_W'(1);
        end
        if (dc_r == 2'd2) begin
          dc_nxt = 2'd0;
          dr_nxt = dr_r + 2'd1;
        end else begin
          dc_nxt = dc_r + 2'd1;
        end
        if (dr_r == 2'd2 && dc_r == 2'd2) begin
          st_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        st_nxt = ST_PREP;
      end
      ST_PREP: begin
        for (int ch = 0; ch < 3; ch++) begin
          rem_nxt[ch] = {sum_r[ch], 1'b0} + bb3_pkg::NUM_W'(cnt_r);
          quo_nxt[ch] = '0;
        end
        step_nxt = '1;
        st_nxt   = ST_DIV;
      end
      ST_DIV: begin
        for (int ch = 0; ch < 3; ch++) begin
          if (rem_r[ch] >= dsh) begin
            rem_nxt[ch]         = rem_r[ch] - dsh;
            quo_nxt[ch][step_r] = 1'b1;
          end
        end
        if (step_r == '0) begin
          st_nxt = ST_OUT;
        end else begin
          step_nxt = step_r - bb3_pkg::STEP_W'(1);
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.out_row     = orow;
          out_data_nxt.out_col     = ocol;
          out_data_nxt.red_out     = quo_r[0];
          out_data_nxt.green_out   = quo_r[1];
          out_data_nxt.blue_out    = quo_r[2];
          out_data_nxt.last_of_run = job_last;
          if (job_last) begin
            st_nxt = ST_IDLE;
          end else begin
            // advance to the next output in raster order
            if (col_job_last) begin
              jj_nxt = 1'b0;
              ji_nxt = 1'b1;
            end else begin
              jj_nxt = 1'b1;
            end
            dr_nxt  = 2'd0;
            dc_nxt  = 2'd0;
            cnt_nxt = '0;
            for (int ch = 0; ch < 3; ch++) begin
              sum_nxt[ch] = '0;
            end
            st_nxt = ST_READ;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      acc_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      acc_en_r    <= (st_r == ST_READ) && nb_ok;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r      <= ent_nxt;
    ji_r       <= ji_nxt;
    jj_r       <= jj_nxt;
    dr_r       <= dr_nxt;
    dc_r       <= dc_nxt;
    cnt_r      <= cnt_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
    for (int ch = 0; ch < 3; ch++) begin
      sum_r[ch] <= sum_nxt[ch];
      rem_r[ch] <= rem_nxt[ch];
      quo_r[ch] <= quo_nxt[ch];
    end
  end

  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_OUT) |-> (cnt_r != '0))
    else $error("output with empty neighborhood");

  a_acc_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    acc_en_r |-> $past(st_r == ST_READ))
    else $error("accumulate without a store read");

  a_quotient_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV && step_r == '1) |->
      (rem_r[0] < (bb3_pkg::NUM_W'(divisor) << 8) &&
       rem_r[1] < (bb3_pkg::NUM_W'(divisor) << 8) &&
       rem_r[2] < (bb3_pkg::NUM_W'(divisor) << 8)))
    else $error("quotient overflows channel width");

endmodule

`default_nettype wire

FILE: rtl/core/box_blur_3x3_edge_aware_top.sv
// ---------------------------------------------------------------------------
// box_blur_3x3_edge_aware_top
// Edge-aware 3x3 box blur over a raster RGB stream.
// ---------------------------------------------------------------------------
// A pixel that completes no output queues no request. Each output runs the
// back end through nine reads via the single read port of the line store,
// the ACC state to finish the sum, the PREP state to set up the divide, eight
// restoring-divide steps shared by the three channels, and the OUT state to
// load the output register; a pixel that completes k outputs (k up to 4) thus
// ties up the back end for k such passes plus the IDLE state that picks up the
// request, plus any waits of the output register on out_ready. The front end
// takes the next pixel as soon as the request queue is empty, so it runs ahead
// of the back end by one request; the first pixel of a frame waits for the
// back end to drain. The line store needs no clearing after reset.
`default_nettype none

module box_blur_3x3_edge_aware_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire bb3_pkg::in_pix_t               in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output bb3_pkg::out_pix_t                   out_data,
  input  wire logic                           cfg_we,
  input  wire logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [bb3_pkg::SIZE_W-1:0]     cfg_wdata
);

  logic                          push;
  bb3_pkg::q_entry_t             push_entry;
  logic                          q_empty;
  logic                          q_pop;
  bb3_pkg::q_entry_t             q_head;
  logic                          back_busy;
  logic                          st_we;
  logic [bb3_pkg::ADDR_W-1:0]    st_addr;
  logic [bb3_pkg::PIX_W-1:0]     st_wdata;
  logic [bb3_pkg::ADDR_W-1:0]    rd_addr;
  logic [bb3_pkg::PIX_W-1:0]     rd_data;
  bb3_pkg::size_t                size;

  bb3_ram #(
    .WIDTH (bb3_pkg::PIX_W),
    .DEPTH (bb3_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_addr),
    .wdata (st_wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  bb3_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .q_empty    (q_empty),
    .back_busy  (back_busy),
    .push       (push),
    .push_entry (push_entry),
    .st_we      (st_we),
    .st_addr    (st_addr),
    .st_wdata   (st_wdata),
    .size       (size)
  );

  bb3_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  bb3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .size      (size),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .busy      (back_busy),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
